@@ rtl/mtf_pkg.sv @@
// Package for the move-to-front table: item types, cell control struct,
// sequencer states and shared constants. No dependencies.
package mtf_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths of the items
    localparam int KEY_W   = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Item modes
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_GET = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key_element;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic               added;
        logic               full_reject;
        logic [KEY_W-1:0]   stored_value;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic capture;  // register the match flag against the incoming key
        logic shift;    // move-to-front: cells up to the hit take their left neighbour
        logic append;   // write the key into the first free cell
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

@@ rtl/mtf_cell.sv @@
// One entry of the move-to-front table: stored element, registered match flag
// and the priority and shift links to its neighbours. Uses mtf_pkg.
module mtf_cell
    import mtf_pkg::*;
#(
    parameter int STORE_W = ELEM_WIDTH_DEF,
    parameter int CNT_W   = 5,
    parameter int INDEX   = 0
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [STORE_W-1:0] i_key,
    input  logic [STORE_W-1:0] i_mask,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [STORE_W-1:0] i_prev_value,
    input  logic               i_seen,
    output logic [STORE_W-1:0] o_value,
    output logic               o_seen,
    output logic               o_first
);

    logic [STORE_W-1:0] r_value;
    logic               r_match;
    logic               w_occupied;
    logic               w_tail;
    logic               w_eq;

    // Position against the fill count
    assign w_occupied = (i_count > CNT_W'(INDEX));
    assign w_tail     = (i_count == CNT_W'(INDEX));
    assign w_eq       = (((r_value ^ i_key) & i_mask) == '0);

    // Capture the match flag when an item is taken
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_match <= w_occupied && w_eq;
        end
    end

    // Shift towards the back on a move, or take the key on an append
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift && !i_seen) begin
            r_value <= i_prev_value;
        end else if (i_ctrl.append && w_tail) begin
            r_value <= i_key;
        end
    end

    // Pass the priority on: only the first matching cell reports itself
    assign o_seen  = i_seen | r_match;
    assign o_first = r_match & ~i_seen;
    assign o_value = r_value;

endmodule

@@ rtl/move_to_front_table_top.sv @@
// Top level of the move-to-front table: sequencer, fill count, mask register,
// result register and the row of mtf_cell instances. Uses mtf_pkg and mtf_cell.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-------------------------
//  input   | i_in_valid   | o_in_ready   | i_in_item  (t_in_item)
//  result  | o_out_valid  | i_out_ready  | o_out_item (t_out_item)
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_data (compare mask)
//
// An item is taken in idle, where every cell compares its entry with the key;
// the update state then resolves the first match along the cell row and
// applies the move, append and result together.
// A waiting result holds the update cycle only when the result register is
// still full; the input is free again as soon as the update is done.
// Reset empties the table and sets the mask to all ones.
module move_to_front_table_top
    import mtf_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [KEY_W-1:0] i_cfg_data
);

    // Only the low key bits can ever be non-zero in an entry
    localparam int STORE_W = (ELEM_WIDTH < KEY_W) ? ELEM_WIDTH : KEY_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);

    t_state             r_state;
    t_state             n_state;
    logic               r_mode;
    logic [STORE_W-1:0] r_key;
    logic [KEY_W-1:0]   r_mask;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               w_accept;
    logic               w_upd_go;
    logic               w_hit;
    logic               w_room;
    logic [STORE_W-1:0] w_key;
    logic [STORE_W-1:0] w_hit_value;
    logic [IDX_W-1:0]   w_pos;
    t_cell_ctrl         w_ctrl;

    logic [STORE_W-1:0] w_val [CAPACITY];
    logic [CAPACITY:0]  w_seen;
    logic [CAPACITY-1:0] w_first;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_upd_go = (r_state == ST_UPDATE) && (!r_out_valid || i_out_ready);
    assign w_hit    = w_seen[CAPACITY];
    assign w_room   = (r_count < CNT_W'(CAPACITY));

    // Cells compare against the port key at acceptance, then the held key
    assign w_key = (r_state == ST_IDLE) ? i_in_item.key_element[STORE_W-1:0] : r_key;

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_upd_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs; in idle the input is always ready, so valid takes the item
    always_comb begin
        o_in_ready = 1'b0;
        w_ctrl     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                w_ctrl.capture = i_in_valid;
            end
            ST_UPDATE: begin
                w_ctrl.shift  = w_upd_go && (r_mode == MODE_GET) && w_hit;
                w_ctrl.append = w_upd_go && (r_mode == MODE_ADD) && !w_hit && w_room;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the item for the update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_in_item.mode;
            r_key  <= i_in_item.key_element[STORE_W-1:0];
        end
    end

    // Compare mask register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    // Row of cells; the first cell takes the hit value on a move
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [STORE_W-1:0] w_prev;

        if (g == 0) begin : g_front
            assign w_prev = w_hit_value;
        end else begin : g_rest
            assign w_prev = w_val[g-1];
        end

        mtf_cell #(
            .STORE_W (STORE_W),
            .CNT_W   (CNT_W),
            .INDEX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_key        (w_key),
            .i_mask       (r_mask[STORE_W-1:0]),
            .i_count      (r_count),
            .i_prev_value (w_prev),
            .i_seen       (w_seen[g]),
            .o_value      (w_val[g]),
            .o_seen       (w_seen[g+1]),
            .o_first      (w_first[g])
        );
    end

    // Gather value and position of the first match
    always_comb begin
        w_hit_value = '0;
        w_pos       = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_hit_value = w_hit_value | w_val[i];
                w_pos       = w_pos | IDX_W'(i);
            end
        end
    end

    // Fill count
    always_comb begin
        n_count = r_count;
        if (w_ctrl.append) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Build the result item
    always_comb begin
        n_out                = '0;
        n_out.hit            = w_hit;
        n_out.added          = (r_mode == MODE_ADD) && !w_hit && w_room;
        n_out.full_reject    = (r_mode == MODE_ADD) && !w_hit && !w_room;
        n_out.stored_value   = ((r_mode == MODE_GET) && w_hit) ? KEY_W'(w_hit_value) : '0;
        n_out.found_position = w_hit ? POS_W'(w_pos) : '0;
        n_out.entry_count    = COUNT_W'(n_count);
    end

    // Result register: load on update, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_single_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $onehot0(w_first))
        else $error("more than one cell claims the first match");

    a_append_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.append |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance the fill count");

    a_accept_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPDATE) && !o_in_ready)
        else $error("taken item did not reach the update cycle");
`endif

endmodule

@@ tb/move_to_front_table_top_tb.sv @@
// Testbench for move_to_front_table_top: sends add and get items and the compare mask,
// predicts each result from its own copy of the table and checks it field by field.
// Depends on mtf_pkg and the RTL of move_to_front_table_top.
module move_to_front_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtf_pkg::*;

    localparam int TABLE_DEPTH    = CAPACITY_DEF;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 50;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [KEY_W-1:0] cfg_data  = '0;

    // Shadow table and fill count, advanced as items are accepted, and shadow mask
    logic [KEY_W-1:0] model_entries [TABLE_DEPTH];
    int unsigned      model_fill   = 0;
    logic [KEY_W-1:0] model_mask   = '1;
    t_out_item        pending_results [$];

    int unsigned      error_count  = 0;
    int unsigned      result_count = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      stall_left   = 0;
    bit               calm         = 1'b0;  // last stretch: no new random gaps or stalls
    bit               gaps_on      = 1'b1;
    bit               stalls_on    = 1'b1;

    // Clock: 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    move_to_front_table_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Work out the result of one item and advance the shadow table
    function automatic t_out_item mtf_predict(t_in_item it);
        t_out_item        res;
        int               found;
        logic [KEY_W-1:0] moved;
        res   = '0;
        found = -1;
        for (int i = 0; i < int'(model_fill); i++) begin
            if (found < 0 && ((model_entries[i] ^ it.key_element) & model_mask) == '0)
                found = i;
        end
        if (it.mode == MODE_ADD) begin
            if (found >= 0) begin
                res.hit            = 1'b1;
                res.found_position = POS_W'(found);
            end else if (model_fill < TABLE_DEPTH) begin
                model_entries[model_fill] = it.key_element;
                model_fill++;
                res.added = 1'b1;
            end else begin
                res.full_reject = 1'b1;
            end
        end else if (found >= 0) begin
            // move the hit to the front, shift the ones ahead of it back by one
            moved = model_entries[found];
            for (int i = found; i > 0; i--)
                model_entries[i] = model_entries[i - 1];
            model_entries[0]   = moved;
            res.hit            = 1'b1;
            res.stored_value   = moved;
            res.found_position = POS_W'(found);
        end
        res.entry_count = COUNT_W'(model_fill);
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t result %0d: %s got %0h, expected %0h",
                     $time, result_count, what, got, want);
    endtask

    // Offer one item, hold it until taken, then record its expected result
    task automatic send_item(logic mode, logic [KEY_W-1:0] key);
        t_in_item it;
        it.mode        = mode;
        it.key_element = key;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        pending_results.push_back(mtf_predict(it));
    endtask

    task automatic idle_input(int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 63) == 0)
            gaps_on = !gaps_on;
        if (!calm && gaps_on && $urandom_range(0, 3) == 0)
            idle_input($urandom_range(1, 16));
    endtask

    // Write the compare mask once the table has gone quiet
    task automatic write_mask(logic [KEY_W-1:0] mask);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data  <= mask;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        model_mask = mask;
        cfg_valid <= 1'b0;
    endtask

    // Mostly look up present entries, with bits outside the mask disturbed
    task automatic send_random_item();
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        pick = $urandom_range(0, 19);
        if (model_fill != 0 && pick < 13)
            key = model_entries[$urandom_range(0, model_fill - 1)] ^ ($urandom() & ~model_mask);
        else if (pick < 18)
            key = $urandom();
        else if (pick == 18)
            key = '0;
        else
            key = '1;
        send_item(1'($urandom_range(0, 1)), key);
    endtask

    // Empty table, extreme keys, duplicate add, filling, full table, moves
    task automatic test_directed_table();
        send_item(MODE_GET, '0);
        send_item(MODE_ADD, '0);
        send_item(MODE_ADD, '1);
        send_item(MODE_ADD, '1);
        for (int i = 2; i < TABLE_DEPTH; i++)
            send_item(MODE_ADD, {8'(i), 8'hC3, 8'(i * 3), 8'h3C});
        send_item(MODE_ADD, 32'h1234_5678);
        send_item(MODE_ADD, model_entries[9]);
        send_item(MODE_GET, model_entries[TABLE_DEPTH - 1]);
        send_item(MODE_GET, model_entries[0]);
        send_item(MODE_GET, 32'hDEAD_BEEF);
        send_item(MODE_GET, model_entries[7]);
    endtask

    // Several matching entries under a narrow mask, then everything matching
    task automatic test_directed_masks();
        write_mask(32'h0000_00FF);
        send_item(MODE_GET, 32'h0000_003C);
        send_item(MODE_ADD, 32'hABCD_EF3C);
        write_mask(32'h0000_0000);
        send_item(MODE_GET, 32'h5555_AAAA);
        send_item(MODE_ADD, 32'hAAAA_5555);
    endtask

    // Random items under one mask, with a full drain halfway through
    task automatic test_random_phase(logic [KEY_W-1:0] mask, int unsigned count);
        write_mask(mask);
        for (int unsigned n = 0; n < count; n++) begin
            send_random_item();
            if (n == count / 2)
                wait_drained();
            else
                random_gap();
        end
    endtask

    task automatic test_final_stretch();
        calm = 1'b1;
        test_random_phase(32'hFFFF_FFFF, 350);
    endtask

    // Result side: stall in random bursts, with stretches of none
    always @(posedge clk) begin
        if ($urandom_range(0, 127) == 0)
            stalls_on = !stalls_on;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 15);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                note_mismatch("result with no item pending", out_item, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_item.hit !== want.hit)
                    note_mismatch("hit", out_item.hit, want.hit);
                if (out_item.added !== want.added)
                    note_mismatch("added", out_item.added, want.added);
                if (out_item.full_reject !== want.full_reject)
                    note_mismatch("full_reject", out_item.full_reject, want.full_reject);
                if (out_item.stored_value !== want.stored_value)
                    note_mismatch("stored_value", out_item.stored_value, want.stored_value);
                if (out_item.found_position !== want.found_position)
                    note_mismatch("found_position", out_item.found_position,
                                  want.found_position);
                if (out_item.entry_count !== want.entry_count)
                    note_mismatch("entry_count", out_item.entry_count, want.entry_count);
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
            || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, run the tests in turn, drain and report
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_table();
        test_directed_masks();
        test_random_phase(32'hFFFF_FFFF, 220);
        test_random_phase(32'h0000_FFFF, 200);
        test_random_phase(32'hFFFF_0000, 200);
        test_random_phase(32'h0000_000F, 200);
        test_random_phase(32'h8000_0001, 200);
        test_random_phase(32'h0000_0000, 150);
        test_random_phase($urandom(), 200);
        test_final_stretch();
        wait_drained();
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ move_to_front_table_top.f @@
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/move_to_front_table_top.sv
tb/move_to_front_table_top_tb.sv
